### rtl/core/ptms_pkg.sv
// shared types and constants for the point-in-triangle mesh search block
package ptms_pkg;

	localparam int COORD_BITS       = 16;
	localparam int INDEX_BITS       = 10;
	localparam int NUM_BITS         = 11;
	localparam int MAX_TRIANGLES_DEF = 1024;
	// queue depth must be a power of two, pointers wrap on their own
	localparam int QUEUE_DEPTH      = 2;
	localparam int IN_DATA_BITS     = 144;
	localparam int OUT_DATA_BITS    = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic                  op;
		logic [INDEX_BITS-1:0] triangle_index;
		coord_t                vertex_a_x;
		coord_t                vertex_a_y;
		coord_t                vertex_b_x;
		coord_t                vertex_b_y;
		coord_t                vertex_c_x;
		coord_t                vertex_c_y;
		coord_t                point_x;
		coord_t                point_y;
	} cmd_t;

	typedef struct packed {
		logic                  found;
		logic [INDEX_BITS-1:0] found_index;
	} res_t;

endpackage

### rtl/core/ptms_front.sv
// front end: accepts stream transactions, classifies them and queues commands
module ptms_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ptms_pkg::IN_DATA_BITS-1:0] s_tdata,
	input  logic [0:0]                        s_tuser,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output ptms_pkg::cmd_t                    cmd
);

	localparam int DEPTH = ptms_pkg::QUEUE_DEPTH;
	localparam int QPW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QCW   = $clog2(DEPTH + 1);
	localparam int IB    = ptms_pkg::INDEX_BITS;
	localparam int CB    = ptms_pkg::COORD_BITS;

	ptms_pkg::cmd_t queue_q [DEPTH];
	ptms_pkg::cmd_t in_cmd;
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;

	// unpack the transaction into a command
	always_comb begin
		in_cmd.op             = s_tuser[0];
		in_cmd.triangle_index = s_tdata[IB-1:0];
		in_cmd.vertex_a_x     = s_tdata[IB + 0*CB +: CB];
		in_cmd.vertex_a_y     = s_tdata[IB + 1*CB +: CB];
		in_cmd.vertex_b_x     = s_tdata[IB + 2*CB +: CB];
		in_cmd.vertex_b_y     = s_tdata[IB + 3*CB +: CB];
		in_cmd.vertex_c_x     = s_tdata[IB + 4*CB +: CB];
		in_cmd.vertex_c_y     = s_tdata[IB + 5*CB +: CB];
		in_cmd.point_x        = s_tdata[IB + 6*CB +: CB];
		in_cmd.point_y        = s_tdata[IB + 7*CB +: CB];
	end

	assign s_tready  = (cnt_q != QCW'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

### rtl/core/ptms_back.sv
// back end: triangle memories, scan sequencer, edge-sign pipeline, result register
module ptms_back #(
	parameter int MAX_TRIANGLES = ptms_pkg::MAX_TRIANGLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ptms_pkg::NUM_BITS-1:0] num_triangles,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  ptms_pkg::cmd_t                cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ptms_pkg::res_t                res
);

	localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int CW = $clog2(MAX_TRIANGLES + 1);
	localparam int IB = ptms_pkg::INDEX_BITS;
	localparam int CB = ptms_pkg::COORD_BITS;
	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;
	localparam int EW = PW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	function automatic logic signed [DW-1:0] sub_ext(
		input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] b
	);
		return {a[CB-1], a} - {b[CB-1], b};
	endfunction

	function automatic logic signed [EW-1:0] sub_prod(
		input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b
	);
		return {a[PW-1], a} - {b[PW-1], b};
	endfunction

	logic [2*CB-1:0] mem_a [MAX_TRIANGLES];
	logic [2*CB-1:0] mem_b [MAX_TRIANGLES];
	logic [2*CB-1:0] mem_c [MAX_TRIANGLES];

	logic [1:0]    state_q;
	logic [CW-1:0] issue_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	ptms_pkg::coord_t px_q;
	ptms_pkg::coord_t py_q;
	logic          done_found_q;
	logic [IB-1:0] done_idx_q;
	logic          res_valid_q;
	ptms_pkg::res_t res_q;

	logic          take;
	logic          is_query;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          issue_en;
	logic          stop;
	logic          last_s4;
	logic          res_load;

	// pipeline
	logic          v_s1, v_s2, v_s3, v_s4;
	logic [CW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [2*CB-1:0] rd_a_s1, rd_b_s1, rd_c_s1;
	logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
	logic signed [DW-1:0] dif_s2 [12];
	logic signed [PW-1:0] prod_s3 [6];
	logic signed [EW-1:0] e1, e2, e3;
	logic          neg, pos;
	logic          hit_s4;

	assign cmd_ready = (state_q == ST_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign is_query  = (cmd.op == ptms_pkg::OP_QUERY);
	assign wr_en     = take && !is_query && (32'(cmd.triangle_index) < MAX_TRIANGLES);
	assign wr_addr   = AW'(cmd.triangle_index);
	assign count_d   = (32'(num_triangles) > MAX_TRIANGLES) ? CW'(MAX_TRIANGLES)
	                                                        : CW'(num_triangles);
	assign last_s4   = ((idx_s4 + 1'b1) == count_q);
	assign stop      = v_s4 && (hit_s4 || last_s4);
	assign issue_en  = (state_q == ST_SCAN) && (issue_q < count_q) && !stop;
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_q      <= '0;
			count_q      <= '0;
			px_q         <= '0;
			py_q         <= '0;
			done_found_q <= 1'b0;
			done_idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && is_query) begin
						count_q      <= count_d;
						issue_q      <= '0;
						px_q         <= cmd.point_x;
						py_q         <= cmd.point_y;
						done_found_q <= 1'b0;
						done_idx_q   <= '0;
						state_q      <= (count_d == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (stop) begin
						done_found_q <= hit_s4;
						done_idx_q   <= hit_s4 ? IB'(idx_s4) : '0;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// valid bits; a hit or the last entry flushes everything behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue_en;
			v_s2 <= v_s1 && !stop;
			v_s3 <= v_s2 && !stop;
			v_s4 <= v_s3 && !stop;
		end
	end

	// triangle store: x in the low half, y in the high half
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= {cmd.vertex_a_y, cmd.vertex_a_x};
			mem_b[wr_addr] <= {cmd.vertex_b_y, cmd.vertex_b_x};
			mem_c[wr_addr] <= {cmd.vertex_c_y, cmd.vertex_c_x};
		end
		if (issue_en) begin
			rd_a_s1 <= mem_a[issue_q[AW-1:0]];
			rd_b_s1 <= mem_b[issue_q[AW-1:0]];
			rd_c_s1 <= mem_c[issue_q[AW-1:0]];
			idx_s1  <= issue_q;
		end
	end

	assign ax = rd_a_s1[CB-1:0];
	assign ay = rd_a_s1[2*CB-1:CB];
	assign bx = rd_b_s1[CB-1:0];
	assign by = rd_b_s1[2*CB-1:CB];
	assign cx = rd_c_s1[CB-1:0];
	assign cy = rd_c_s1[2*CB-1:CB];

	// edge(p, q, r) = (px - rx) * (qy - ry) - (qx - rx) * (py - ry)
	// edges: (a, b), (b, c), (c, a)
	always_ff @(posedge clk) begin
		dif_s2[0]  <= sub_ext(px_q, bx);
		dif_s2[1]  <= sub_ext(ay, by);
		dif_s2[2]  <= sub_ext(ax, bx);
		dif_s2[3]  <= sub_ext(py_q, by);
		dif_s2[4]  <= sub_ext(px_q, cx);
		dif_s2[5]  <= sub_ext(by, cy);
		dif_s2[6]  <= sub_ext(bx, cx);
		dif_s2[7]  <= sub_ext(py_q, cy);
		dif_s2[8]  <= sub_ext(px_q, ax);
		dif_s2[9]  <= sub_ext(cy, ay);
		dif_s2[10] <= sub_ext(cx, ax);
		dif_s2[11] <= sub_ext(py_q, ay);
		idx_s2     <= idx_s1;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			prod_s3[k] <= dif_s2[2*k] * dif_s2[2*k+1];
		end
		idx_s3 <= idx_s2;
	end

	assign e1  = sub_prod(prod_s3[0], prod_s3[1]);
	assign e2  = sub_prod(prod_s3[2], prod_s3[3]);
	assign e3  = sub_prod(prod_s3[4], prod_s3[5]);
	assign neg = e1[EW-1] || e2[EW-1] || e3[EW-1];
	assign pos = (!e1[EW-1] && (e1 != '0)) || (!e2[EW-1] && (e2 != '0))
	          || (!e3[EW-1] && (e3 != '0));

	always_ff @(posedge clk) begin
		hit_s4 <= !(neg && pos);
		idx_s4 <= idx_s3;
	end

	// output register, parts the scan from the downstream side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.found       <= done_found_q;
			res_q.found_index <= done_idx_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_flush_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && stop) |=> !(v_s1 || v_s2 || v_s3 || v_s4))
		else $error("pipeline not flushed after scan end");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= count_q))
		else $error("scan issued past the triangle count");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (idx_s4 < count_q))
		else $error("tested entry outside scanned range");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result loaded outside done state");

endmodule

### rtl/core/point_in_triangle_mesh_search_top.sv
// top level of the point-in-triangle mesh search: config register, front end, back end
// a write transaction is stored in the back end when taken and gives no result
// a query raises m_tvalid once the scan stops at its first containing triangle k or, on a miss,
// after all n triangles; an empty scan goes straight to done; one triangle is tested per cycle,
// set by the single read port of the triangle memory feeding a four-stage edge pipeline
// reset clears control state and num_triangles to 0; the triangle memory is not cleared
module point_in_triangle_mesh_search_top #(
	parameter int MAX_TRIANGLES = ptms_pkg::MAX_TRIANGLES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// triangle_index, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
	// vertex_c_x, vertex_c_y, point_x, point_y, zero pad
	input  logic [ptms_pkg::IN_DATA_BITS-1:0]  s_tdata,
	// operation
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// found_index, zero pad
	output logic [ptms_pkg::OUT_DATA_BITS-1:0] m_tdata,
	// found
	output logic [0:0]                         m_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ptms_pkg::NUM_BITS-1:0]      cfg_data
);

	logic [ptms_pkg::NUM_BITS-1:0] num_q;
	logic           cmd_valid;
	logic           cmd_ready;
	ptms_pkg::cmd_t cmd;
	ptms_pkg::res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			num_q <= cfg_data;
		end
	end

	ptms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	ptms_back #(
		.MAX_TRIANGLES (MAX_TRIANGLES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.num_triangles (num_q),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res           (res)
	);

	assign m_tdata = {{(ptms_pkg::OUT_DATA_BITS - ptms_pkg::INDEX_BITS){1'b0}},
	                  res.found_index};
	assign m_tuser = res.found;

endmodule
